FILE: rtl/complex_arithmetic_unit_assert.svh
// Assertion macros for the complex arithmetic unit.
// Used by files that need clocked checks on i_clk / i_rst_n.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cau_pkg.sv
// Package for the complex arithmetic unit: opcodes, payload and tag types.
// No dependencies.
package cau_pkg;

    localparam int CAU_W  = 16;
    localparam int CAU_SW = 2 * CAU_W + 1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                 opcode;
        logic signed [CAU_W-1:0] a_real;
        logic signed [CAU_W-1:0] a_imag;
        logic signed [CAU_W-1:0] b_real;
        logic signed [CAU_W-1:0] b_imag;
    } t_in;

    typedef struct packed {
        logic signed [CAU_W-1:0] res_real;
        logic signed [CAU_W-1:0] res_imag;
        logic                    operands_equal;
        logic                    div_by_zero;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        t_opcode op;
        logic    eq;
        logic    dz;
        logic    neg_re;
        logic    neg_im;
        logic    ov_re;
        logic    ov_im;
    } t_tag;

endpackage

FILE: rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front end, division stages and
// saturating output register. Depends on cau_pkg, cau_front, cau_div_step.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------
//   in       | i_in_valid / o_in_ready    | i_in_data  (t_in)
//   out      | o_out_valid / i_out_ready  | o_out_data (t_out)
//
// One transaction per cycle while the output is not stalled; every result passes
// 3 front stages, 18 division stages and 1 output register, the same for every opcode.
// Each stage advances when it is empty or its successor advances, so bubbles
// collapse and a stalled output still lets earlier stages fill.
// Synchronous active-low reset clears all valid bits.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cau_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cau_pkg::t_out o_out_data
);
    import cau_pkg::*;

    localparam int RW    = 3 * CAU_W + FRAC_BITS + 2;
    localparam int NSTEP = CAU_W + 2;
    localparam int NS    = NSTEP + 4;

    logic [NS-1:0]      w_vld, w_en;
    t_tag               w_tag    [0:NSTEP];
    logic [2*CAU_W-1:0] w_den    [0:NSTEP];
    logic [RW-1:0]      w_rem_re [0:NSTEP];
    logic [RW-1:0]      w_rem_im [0:NSTEP];
    logic [CAU_W:0]     w_q_re   [0:NSTEP];
    logic [CAU_W:0]     w_q_im   [0:NSTEP];
    logic [2:0]         w_fvld;

    logic               r_out_vld;
    t_out               r_out, n_out;

    always_comb begin
        w_en[NS-1] = !w_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !w_vld[k] || w_en[k+1];
        end
    end

    cau_front #(
        .FRAC_BITS (FRAC_BITS),
        .RW        (RW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en[2:0]),
        .i_vld    (i_in_valid),
        .i_data   (i_in_data),
        .o_vld    (w_fvld),
        .o_tag    (w_tag[0]),
        .o_rem_re (w_rem_re[0]),
        .o_rem_im (w_rem_im[0]),
        .o_den    (w_den[0])
    );

    assign w_vld[2:0] = w_fvld;
    assign w_q_re[0]  = '0;
    assign w_q_im[0]  = '0;

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        cau_div_step #(
            .RW    (RW),
            .SHIFT (CAU_W + 1 - s)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en[s+3]),
            .i_vld    (w_vld[s+2]),
            .i_tag    (w_tag[s]),
            .i_den    (w_den[s]),
            .i_rem_re (w_rem_re[s]),
            .i_rem_im (w_rem_im[s]),
            .i_q_re   (w_q_re[s]),
            .i_q_im   (w_q_im[s]),
            .o_vld    (w_vld[s+3]),
            .o_tag    (w_tag[s+1]),
            .o_den    (w_den[s+1]),
            .o_rem_re (w_rem_re[s+1]),
            .o_rem_im (w_rem_im[s+1]),
            .o_q_re   (w_q_re[s+1]),
            .o_q_im   (w_q_im[s+1])
        );
    end

    function automatic logic [CAU_W:0] f_sat(input logic neg, input logic [CAU_SW-1:0] mag);
        logic [CAU_SW-1:0] lim;
        logic              clip;
        logic [CAU_W-1:0]  val;
        lim  = neg ? (CAU_SW'(1) << (CAU_W - 1)) : ((CAU_SW'(1) << (CAU_W - 1)) - 1'b1);
        clip = mag > lim;
        val  = clip ? lim[CAU_W-1:0] : mag[CAU_W-1:0];
        f_sat = {clip, neg ? (~val + 1'b1) : val};
    endfunction

    t_tag              w_lt;
    logic              w_isdiv;
    logic [CAU_SW-1:0] w_mre, w_mim;
    logic [CAU_W:0]    w_sre, w_sim;

    always_comb begin
        w_lt    = w_tag[NSTEP];
        w_isdiv = (w_lt.op == OP_DIV) && !w_lt.dz;
        if (w_isdiv) begin
            w_mre = w_lt.ov_re ? (CAU_SW'(1) << (CAU_W + 1)) : CAU_SW'(w_q_re[NSTEP]);
            w_mim = w_lt.ov_im ? (CAU_SW'(1) << (CAU_W + 1)) : CAU_SW'(w_q_im[NSTEP]);
        end else begin
            w_mre = w_rem_re[NSTEP][CAU_SW-1:0];
            w_mim = w_rem_im[NSTEP][CAU_SW-1:0];
        end
        w_sre                = f_sat(w_lt.neg_re, w_mre);
        w_sim                = f_sat(w_lt.neg_im, w_mim);
        n_out.res_real       = w_sre[CAU_W-1:0];
        n_out.res_imag       = w_sim[CAU_W-1:0];
        n_out.operands_equal = w_lt.eq;
        n_out.div_by_zero    = w_lt.dz;
        n_out.saturated      = w_sre[CAU_W] || w_sim[CAU_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en[NS-1]) begin
            r_out_vld <= w_vld[NS-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign w_vld[NS-1] = r_out_vld;
    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `include "complex_arithmetic_unit_assert.svh"

    `CAU_ASSERT_IMP(a_dz_zero, o_out_valid && o_out_data.div_by_zero, o_out_data.res_real == '0 && o_out_data.res_imag == '0 && !o_out_data.saturated, "divide by zero result not clean")
    `CAU_ASSERT_IMP(a_dz_op, w_vld[2] && w_tag[0].op != OP_DIV, !w_tag[0].dz, "div_by_zero on non-divide")
    `CAU_ASSERT_NXT(a_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

FILE: rtl/cau_front.sv
// Front end: products, sums and divisor, then sign/magnitude split.
// Three register stages. Depends on cau_pkg.
module cau_front #(
    parameter int FRAC_BITS = 8,
    parameter int RW        = 66
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_en,
    input  logic               i_vld,
    input  cau_pkg::t_in       i_data,
    output logic [2:0]         o_vld,
    output cau_pkg::t_tag      o_tag,
    output logic [RW-1:0]      o_rem_re,
    output logic [RW-1:0]      o_rem_im,
    output logic [2*cau_pkg::CAU_W-1:0] o_den
);
    import cau_pkg::*;

    logic [2:0] r_vld;

    // stage 1
    logic signed [2*CAU_W-1:0] r1_prr, r1_pii, r1_pri, r1_pir, r1_sqr, r1_sqi;
    logic signed [CAU_W:0]     r1_sre, r1_sim;
    t_tag                      r1_tag;

    // stage 2
    logic signed [CAU_SW-1:0]  r2_re, r2_im;
    logic [2*CAU_W-1:0]        r2_den;
    t_tag                      r2_tag;

    // stage 3
    logic [RW-1:0]             r3_re, r3_im;
    logic [2*CAU_W-1:0]        r3_den;
    t_tag                      r3_tag;

    logic signed [CAU_W:0]     n1_sre, n1_sim;
    t_tag                      n1_tag;
    logic signed [CAU_SW-1:0]  n2_re, n2_im, w_mre, w_mim;
    logic [2*CAU_W-1:0]        n2_den;
    t_tag                      n2_tag;
    logic [CAU_SW-1:0]         w_mag_re, w_mag_im;
    logic [RW-1:0]             n3_re, n3_im;
    t_tag                      n3_tag;

    always_comb begin
        n1_tag        = '0;
        n1_tag.op     = i_data.opcode;
        n1_tag.eq     = (i_data.a_real == i_data.b_real) && (i_data.a_imag == i_data.b_imag);
        if (i_data.opcode == OP_SUB) begin
            n1_sre = (CAU_W+1)'(i_data.a_real) - (CAU_W+1)'(i_data.b_real);
            n1_sim = (CAU_W+1)'(i_data.a_imag) - (CAU_W+1)'(i_data.b_imag);
        end else begin
            n1_sre = (CAU_W+1)'(i_data.a_real) + (CAU_W+1)'(i_data.b_real);
            n1_sim = (CAU_W+1)'(i_data.a_imag) + (CAU_W+1)'(i_data.b_imag);
        end
    end

    always_comb begin
        n2_tag = r1_tag;
        w_mre  = CAU_SW'(r1_prr) - CAU_SW'(r1_pii);
        w_mim  = CAU_SW'(r1_pri) + CAU_SW'(r1_pir);
        n2_den = $unsigned(r1_sqr) + $unsigned(r1_sqi);
        case (r1_tag.op)
            OP_ADD, OP_SUB: begin
                n2_re = CAU_SW'(r1_sre);
                n2_im = CAU_SW'(r1_sim);
            end
            OP_MUL: begin
                n2_re = w_mre >>> FRAC_BITS;
                n2_im = w_mim >>> FRAC_BITS;
            end
            default: begin
                n2_re = CAU_SW'(r1_prr) + CAU_SW'(r1_pii);
                n2_im = CAU_SW'(r1_pir) - CAU_SW'(r1_pri);
            end
        endcase
        n2_tag.dz = (r1_tag.op == OP_DIV) && (n2_den == '0);
    end

    always_comb begin
        n3_tag        = r2_tag;
        n3_tag.neg_re = r2_re[CAU_SW-1] && !r2_tag.dz;
        n3_tag.neg_im = r2_im[CAU_SW-1] && !r2_tag.dz;
        w_mag_re      = r2_re[CAU_SW-1] ? $unsigned(-r2_re) : $unsigned(r2_re);
        w_mag_im      = r2_im[CAU_SW-1] ? $unsigned(-r2_im) : $unsigned(r2_im);
        if (r2_tag.dz) begin
            n3_re = '0;
            n3_im = '0;
        end else if (r2_tag.op == OP_DIV) begin
            n3_re = RW'(w_mag_re) << FRAC_BITS;
            n3_im = RW'(w_mag_im) << FRAC_BITS;
        end else begin
            n3_re = RW'(w_mag_re);
            n3_im = RW'(w_mag_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_en[0]) r_vld[0] <= i_vld;
            if (i_en[1]) r_vld[1] <= r_vld[0];
            if (i_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_prr <= i_data.a_real * i_data.b_real;
            r1_pii <= i_data.a_imag * i_data.b_imag;
            r1_pri <= i_data.a_real * i_data.b_imag;
            r1_pir <= i_data.a_imag * i_data.b_real;
            r1_sqr <= i_data.b_real * i_data.b_real;
            r1_sqi <= i_data.b_imag * i_data.b_imag;
            r1_sre <= n1_sre;
            r1_sim <= n1_sim;
            r1_tag <= n1_tag;
        end
        if (i_en[1]) begin
            r2_re  <= n2_re;
            r2_im  <= n2_im;
            r2_den <= n2_den;
            r2_tag <= n2_tag;
        end
        if (i_en[2]) begin
            r3_re  <= n3_re;
            r3_im  <= n3_im;
            r3_den <= r2_den;
            r3_tag <= n3_tag;
        end
    end

    assign o_vld    = r_vld;
    assign o_tag    = r3_tag;
    assign o_rem_re = r3_re;
    assign o_rem_im = r3_im;
    assign o_den    = r3_den;

endmodule

FILE: rtl/cau_div_step.sv
// One restoring-division stage for both result parts; the top stage only
// flags quotient overflow. Depends on cau_pkg.
module cau_div_step #(
    parameter int RW    = 66,
    parameter int SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  cau_pkg::t_tag               i_tag,
    input  logic [2*cau_pkg::CAU_W-1:0] i_den,
    input  logic [RW-1:0]               i_rem_re,
    input  logic [RW-1:0]               i_rem_im,
    input  logic [cau_pkg::CAU_W:0]     i_q_re,
    input  logic [cau_pkg::CAU_W:0]     i_q_im,
    output logic                        o_vld,
    output cau_pkg::t_tag               o_tag,
    output logic [2*cau_pkg::CAU_W-1:0] o_den,
    output logic [RW-1:0]               o_rem_re,
    output logic [RW-1:0]               o_rem_im,
    output logic [cau_pkg::CAU_W:0]     o_q_re,
    output logic [cau_pkg::CAU_W:0]     o_q_im
);
    import cau_pkg::*;

    logic                r_vld;
    t_tag                r_tag, n_tag;
    logic [2*CAU_W-1:0]  r_den;
    logic [RW-1:0]       r_rem_re, r_rem_im, n_rem_re, n_rem_im, w_dsh;
    logic [CAU_W:0]      r_q_re, r_q_im, n_q_re, n_q_im, w_bit;
    logic                w_div, w_ge_re, w_ge_im;

    always_comb begin
        w_dsh    = RW'(i_den) << SHIFT;
        w_bit    = (CAU_W+1)'(1) << SHIFT;
        w_div    = (i_tag.op == OP_DIV) && !i_tag.dz;
        w_ge_re  = i_rem_re >= w_dsh;
        w_ge_im  = i_rem_im >= w_dsh;
        n_tag    = i_tag;
        n_rem_re = i_rem_re;
        n_rem_im = i_rem_im;
        n_q_re   = i_q_re;
        n_q_im   = i_q_im;
        if (SHIFT == CAU_W + 1) begin
            n_tag.ov_re = w_div && w_ge_re;
            n_tag.ov_im = w_div && w_ge_im;
        end else begin
            if (w_div && !i_tag.ov_re && w_ge_re) begin
                n_rem_re = i_rem_re - w_dsh;
                n_q_re   = i_q_re | w_bit;
            end
            if (w_div && !i_tag.ov_im && w_ge_im) begin
                n_rem_im = i_rem_im - w_dsh;
                n_q_im   = i_q_im | w_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag    <= n_tag;
            r_den    <= i_den;
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_q_re   <= n_q_re;
            r_q_im   <= n_q_im;
        end
    end

    assign o_vld    = r_vld;
    assign o_tag    = r_tag;
    assign o_den    = r_den;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;

endmodule
